>>> rtl/pfr_pkg.sv
package pfr_pkg;

  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FRAMES_IN_USE_RESET = 5'd12;

  typedef struct packed {
    logic [31:0] page_key;
    logic        is_write;
  } pfr_in_t;

  typedef struct packed {
    logic        hit;
    logic        evicted_dirty;
    logic [31:0] evicted_key;
    logic [31:0] fault_total;
    logic [31:0] writeback_total;
  } pfr_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } pfr_cmd_t;

endpackage

>>> rtl/pfr_ctrl.sv
module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pfr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.load) state_next = S_EXEC;
      S_EXEC: if (cmd.exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC) && !in_ready)
    else $error("accepted beat did not start execution");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");
`endif

endmodule

>>> rtl/pfr_datapath.sv
module pfr_datapath
  import pfr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pfr_cmd_t               cmd,
  input  pfr_in_t                in_data,
  output pfr_out_t               out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int FW = $clog2(MAX_FRAMES + 1);
  localparam int IW = $clog2(MAX_FRAMES);

  logic [KW-1:0]         keys      [MAX_FRAMES];
  logic [KW-1:0]         keys_next [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] dirty, dirty_next;
  logic [FW-1:0]         filled;
  logic [31:0]           fault_counter, fault_next;
  logic [31:0]           writeback_counter, writeback_next;
  logic [KW-1:0]         req_key;
  logic                  req_wr;
  logic                  policy_mode;
  logic [CFG_DATA_W-1:0] frames_in_use;

  logic [FW-1:0]         cap;
  logic [MAX_FRAMES-1:0] match;
  logic                  hit, full, evict, fill, shift;
  logic [IW-1:0]         found, shift_base, tail;
  logic                  tail_dirty;

  always_comb begin
    if (frames_in_use == '0) begin
      cap = FW'(1);
    end else if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
      cap = FW'(MAX_FRAMES);
    end else begin
      cap = FW'(frames_in_use);
    end
  end

  always_comb begin
    found = '0;
    for (int s = 0; s < MAX_FRAMES; s++) begin
      match[s] = (FW'(s) < filled) && (keys[s] == req_key);
    end
    for (int s = MAX_FRAMES - 1; s >= 0; s--) begin
      if (match[s]) found = IW'(s);
    end
  end

  assign hit        = |match;
  assign full       = (filled >= cap);
  assign evict      = !hit && full;
  assign fill       = !hit && !full;
  assign shift      = (hit && (policy_mode == POLICY_LRU)) || evict;
  assign shift_base = hit ? found : '0;
  assign tail       = IW'(filled - FW'(1));
  assign tail_dirty = hit ? (dirty[found] | req_wr) : req_wr;

  always_comb begin
    for (int s = 0; s < MAX_FRAMES; s++) begin
      keys_next[s]  = keys[s];
      dirty_next[s] = dirty[s];
      if (shift && (IW'(s) >= shift_base) && (IW'(s) < tail)) begin
        if (s < MAX_FRAMES - 1) begin
          keys_next[s]  = keys[s+1];
          dirty_next[s] = dirty[s+1];
        end
      end else if (shift && (IW'(s) == tail)) begin
        keys_next[s]  = req_key;
        dirty_next[s] = tail_dirty;
      end else if (fill && (FW'(s) == filled)) begin
        keys_next[s]  = req_key;
        dirty_next[s] = req_wr;
      end else if (hit && (policy_mode == POLICY_FIFO) && (IW'(s) == found)) begin
        dirty_next[s] = dirty[s] | req_wr;
      end
    end
  end

  always_comb begin
    fault_next     = fault_counter;
    writeback_next = writeback_counter;
    if (!hit && (fault_counter != '1)) fault_next = fault_counter + 32'd1;
    if (evict && dirty[0] && (writeback_counter != '1)) begin
      writeback_next = writeback_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty             <= '0;
      filled            <= '0;
      fault_counter     <= '0;
      writeback_counter <= '0;
      policy_mode       <= POLICY_LRU;
      frames_in_use     <= FRAMES_IN_USE_RESET;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_POLICY_MODE:   policy_mode   <= cfg_data[0];
          REG_FRAMES_IN_USE: frames_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        dirty             <= dirty_next;
        fault_counter     <= fault_next;
        writeback_counter <= writeback_next;
        if (fill) filled <= filled + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_key <= in_data.page_key[KW-1:0];
      req_wr  <= in_data.is_write;
    end
    if (cmd.exec) begin
      keys                     <= keys_next;
      out_data.hit             <= hit;
      out_data.evicted_dirty   <= evict && dirty[0];
      out_data.evicted_key     <= evict ? 32'(keys[0]) : '0;
      out_data.fault_total     <= fault_next;
      out_data.writeback_total <= writeback_next;
    end
  end

`ifndef SYNTH
  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FW'(MAX_FRAMES))
    else $error("filled frame count beyond depth");

  a_fault_step: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !hit |=> (fault_counter == $past(fault_counter) + 32'd1) ||
                         ($past(fault_counter) == '1))
    else $error("fault counter did not advance on a miss");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && hit |=> (fault_counter == $past(fault_counter)) &&
                        !out_data.evicted_dirty && (out_data.evicted_key == '0))
    else $error("hit changed fault count or reported an eviction");
`endif

endmodule

>>> rtl/page_frame_replacement_unit.sv
// Page frame replacement unit: fully associative page store with FIFO or LRU
// victim selection, fault and writeback counters.
// Input channel (in_valid/in_ready/in_data): one memory reference per beat,
// a page key and a write flag. Output channel (out_valid/out_ready/out_data):
// one result beat per reference: hit, eviction info and running counters.
// Config port: cfg_write_en/cfg_index/cfg_data, index 0 policy (0 FIFO,
// 1 LRU), index 1 frames in use; write only while no reference is in flight.
// Steps: an accepted reference is captured into the request register, then the
// lookup and the shift of the frame chain run in the execute state, which writes
// the result register; no new reference is taken until that execute is done.
// The result register lets a new reference be accepted while the previous
// result waits; if the receiver stalls, the next reference stays in execute
// until the result register frees, and the input then holds off.
// Reset (synchronous, rst high): no resident pages, counters zero, LRU policy,
// 12 frames in use. No clearing pass is needed.
module page_frame_replacement_unit
  import pfr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pfr_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pfr_out_t               out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pfr_cmd_t cmd;

  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pfr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_data      (in_data),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

>>> test/page_frame_replacement_unit_tb.sv
module page_frame_replacement_unit_tb
  import pfr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES   = 16;
  localparam int STALL_LIMIT  = 1000;
  localparam int SQUEEZE_HOLD = 80;

  // Tracks the resident page chain and counters, queues the expected result beats.
  class frame_store_scoreboard;
    logic [31:0]  keys [NUM_FRAMES];
    bit           dirty [NUM_FRAMES];
    int unsigned  filled;
    logic [31:0]  faults;
    logic [31:0]  writebacks;
    logic         policy;
    logic [4:0]   frames_cfg;
    pfr_out_t     due_outcomes [$];
    int unsigned  errors;

    function new();
      policy     = POLICY_LRU;
      frames_cfg = FRAMES_IN_USE_RESET;
      filled     = 0;
      faults     = '0;
      writebacks = '0;
      errors     = 0;
      foreach (dirty[i]) dirty[i] = 1'b0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_POLICY_MODE) begin
        policy = data[0];
      end else if (idx == REG_FRAMES_IN_USE) begin
        frames_cfg = data;
      end
    endfunction

    function int unsigned capacity();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > NUM_FRAMES) return NUM_FRAMES;
      return frames_cfg;
    endfunction

    function void move_to_tail(input int unsigned s);
      logic [31:0] k;
      bit d;
      int unsigned t;
      k = keys[s];
      d = dirty[s];
      for (t = s; t + 1 < filled; t++) begin
        keys[t]  = keys[t + 1];
        dirty[t] = dirty[t + 1];
      end
      keys[t]  = k;
      dirty[t] = d;
    endfunction

    function void note_reference(input pfr_in_t r);
      int unsigned cap;
      int unsigned slot;
      bit resident;
      pfr_out_t want;
      cap      = capacity();
      resident = 1'b0;
      slot     = 0;
      want     = '0;
      for (int unsigned s = 0; s < filled; s++) begin
        if (!resident && keys[s] == r.page_key) begin
          resident = 1'b1;
          slot     = s;
        end
      end
      if (resident) begin
        if (r.is_write) dirty[slot] = 1'b1;
        if (policy == POLICY_LRU) move_to_tail(slot);
      end else begin
        if (filled < cap) begin
          keys[filled]  = r.page_key;
          dirty[filled] = r.is_write;
          filled++;
        end else begin
          want.evicted_key   = keys[0];
          want.evicted_dirty = dirty[0];
          keys[0]  = r.page_key;
          dirty[0] = r.is_write;
          move_to_tail(0);
          if (want.evicted_dirty && writebacks != '1) writebacks++;
        end
        if (faults != '1) faults++;
      end
      want.hit             = resident;
      want.fault_total     = faults;
      want.writeback_total = writebacks;
      due_outcomes.push_back(want);
    endfunction

    function void check_result(input pfr_out_t got);
      pfr_out_t want;
      if (due_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = due_outcomes.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.evicted_dirty !== want.evicted_dirty) begin
        $error("evicted_dirty: expected %0d, got %0d", want.evicted_dirty, got.evicted_dirty);
        errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
        errors++;
      end
      if (got.fault_total !== want.fault_total) begin
        $error("fault_total: expected %0d, got %0d", want.fault_total, got.fault_total);
        errors++;
      end
      if (got.writeback_total !== want.writeback_total) begin
        $error("writeback_total: expected %0d, got %0d", want.writeback_total,
               got.writeback_total);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  pfr_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  pfr_out_t               out_data;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_store_scoreboard sb = new();

  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_age = 0;
  int unsigned idle_cycles = 0;

  page_frame_replacement_unit #(
    .MAX_FRAMES(NUM_FRAMES),
    .KEY_BITS  (32)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random stall rate picked anew whenever its age counter runs out, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
      stall_age = 40;
    end else begin
      stall_age--;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left = SQUEEZE_HOLD;
      hold_req  = 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pfr_in_t mk_ref(input logic [31:0] key, input logic wr);
    pfr_in_t r;
    r.page_key = key;
    r.is_write = wr;
    return r;
  endfunction

  // holds the beat until accepted; valid is left high for the caller
  task automatic send_ref(input pfr_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_reference(item);
  endtask

  task automatic drain();
    while (sb.due_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic pol, input logic [4:0] frames);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_POLICY_MODE;
    cfg_data     <= {4'b0, pol};
    @(posedge clk);
    sb.set_reg(REG_POLICY_MODE, {4'b0, pol});
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data  <= frames;
    @(posedge clk);
    sb.set_reg(REG_FRAMES_IN_USE, frames);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(input logic pol, input logic [4:0] frames, input int unsigned count,
                           input bit squeeze);
    logic [31:0] pool [20];
    int unsigned pool_n;
    int unsigned burst_left;
    pfr_in_t item;
    drain();
    configure(pol, frames);
    pool_n = sb.capacity() + $urandom_range(0, 4);
    foreach (pool[i]) pool[i] = $urandom;
    if ($urandom_range(0, 1)) begin
      pool[0] = '0;
      pool[1] = '1;
    end
    if (squeeze) hold_req = 1'b1;
    burst_left = $urandom_range(1, 20);
    repeat (count) begin
      item.page_key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                                    : $urandom;
      item.is_write = ($urandom_range(0, 99) < 40);
      send_ref(item);
      if (!squeeze && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else if (burst_left != 0) begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset config: LRU, 12 frames
    send_ref(mk_ref(32'h0000_0000, 1'b1));
    send_ref(mk_ref(32'hFFFF_FFFF, 1'b0));
    send_ref(mk_ref(32'h0000_0000, 1'b0));
    send_ref(mk_ref(32'h1234_5678, 1'b1));
    send_ref(mk_ref(32'hFFFF_FFFF, 1'b1));
    send_ref(mk_ref(32'hA5A5_A5A5, 1'b0));
    in_valid <= 1'b0;

    // capacity shrunk below the resident count
    drain();
    configure(POLICY_LRU, 5'd2);
    send_ref(mk_ref(32'h0000_0001, 1'b0));
    send_ref(mk_ref(32'h0000_0002, 1'b1));
    send_ref(mk_ref(32'h0000_0002, 1'b0));
    send_ref(mk_ref(32'h0000_0003, 1'b0));
    send_ref(mk_ref(32'h0000_0004, 1'b0));
    in_valid <= 1'b0;

    // zero frames acts as one
    drain();
    configure(POLICY_FIFO, 5'd0);
    send_ref(mk_ref(32'h0000_0005, 1'b1));
    send_ref(mk_ref(32'h0000_0005, 1'b0));
    send_ref(mk_ref(32'h0000_0006, 1'b0));
    send_ref(mk_ref(32'h5A5A_5A5A, 1'b1));
    send_ref(mk_ref(32'h8000_0000, 1'b0));
    in_valid <= 1'b0;

    // above the built depth acts as full depth
    drain();
    configure(POLICY_FIFO, 5'd31);
    send_ref(mk_ref(32'h0000_0007, 1'b1));
    send_ref(mk_ref(32'h0000_0008, 1'b0));
    send_ref(mk_ref(32'h0000_0007, 1'b0));
    send_ref(mk_ref(32'h7FFF_FFFF, 1'b1));
    in_valid <= 1'b0;

    run_phase(POLICY_LRU,  5'd12, 45, 1'b0);
    run_phase(POLICY_FIFO, 5'd16, 45, 1'b0);
    run_phase(POLICY_LRU,  5'd1,  40, 1'b0);
    run_phase(POLICY_FIFO, 5'd4,  45, 1'b1);
    run_phase(POLICY_LRU,  5'd31, 50, 1'b0);
    run_phase(POLICY_FIFO, 5'd0,  35, 1'b0);
    run_phase(POLICY_LRU,  5'd3,  45, 1'b0);
    run_phase(POLICY_FIFO, 5'd17, 45, 1'b0);
    run_phase(POLICY_LRU,  5'($urandom_range(0, 31)), 50, 1'b0);
    run_phase(POLICY_FIFO, 5'($urandom_range(0, 31)), 50, 1'b0);

    drain();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.due_outcomes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
